// File: hw/rtl/tup_pkg.sv
package tup_pkg;

    localparam int VALUE_WIDTH_DEF  = 64;
    localparam int OFFSET_WIDTH_DEF = 16;
    localparam int CHAR_WIDTH       = 8;
    localparam int BASE_WIDTH       = 6;
    localparam int DIGIT_WIDTH      = 6;

    localparam logic [BASE_WIDTH-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_WIDTH-1:0] BASE_UNIT = 6'd1;
    localparam logic [BASE_WIDTH-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_WIDTH-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_WIDTH-1:0] BASE_HEX  = 6'd16;
    localparam logic [BASE_WIDTH-1:0] BASE_MAX  = 6'd36;

    localparam logic [CHAR_WIDTH-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_WIDTH-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_WIDTH-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_WIDTH-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_WIDTH-1:0] CH_UPPER_X = 8'h58;
    localparam logic [CHAR_WIDTH-1:0] CH_LOWER_X = 8'h78;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_WIDTH-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_WIDTH-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_WIDTH-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_WIDTH-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_WIDTH-1:0] CH_UPPER_OFS = 8'h37;
    localparam logic [CHAR_WIDTH-1:0] CH_LOWER_OFS = 8'h57;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_SIGNED,
        PH_ZERO,
        PH_AFTER_X,
        PH_DIGITS
    } phase_t;

    typedef enum logic [1:0] {
        DS_NONE,
        DS_SEEN,
        DS_OVF
    } digit_status_t;

    typedef enum logic [1:0] {
        BS_KEEP,
        BS_FIRST,
        BS_ZERO,
        BS_HEX
    } base_sel_t;

    typedef enum logic [1:0] {
        EM_NONE,
        EM_EMPTY,
        EM_VALUE,
        EM_PREFIX
    } emit_t;

    typedef struct packed {
        logic      step;
        logic      restart;
        logic      set_neg;
        logic      mark;
        logic      acc_clear;
        logic      take;
        logic      seen_set;
        base_sel_t base_sel;
        emit_t     emit;
    } cmd_t;

    typedef struct packed {
        logic is_space;
        logic is_minus;
        logic is_plus;
        logic is_zero;
        logic is_x;
        logic hex_digit;
        logic cfg_bad;
        logic cfg_auto_hex;
        logic first_ok;
        logic digit_ok;
    } status_t;

endpackage

// File: hw/rtl/tup_ctrl.sv
module tup_ctrl
    import tup_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    accept,
    input  logic    string_start,
    input  status_t status,
    output cmd_t    cmd
);

    phase_t state_reg;
    phase_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PH_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        phase_t cur_phase;
        cur_phase  = string_start ? PH_LEAD : state_reg;
        state_next = state_reg;
        cmd        = '0;
        if (accept && (string_start || state_reg != PH_IDLE))
        begin
            cmd.step    = 1'b1;
            cmd.restart = string_start;
            unique case (cur_phase) inside
                PH_LEAD, PH_SIGNED:
                begin
                    if (cur_phase == PH_LEAD && status.is_space)
                    begin
                        state_next = PH_LEAD;
                    end
                    else if (cur_phase == PH_LEAD && status.is_minus)
                    begin
                        cmd.set_neg = 1'b1;
                        state_next  = PH_SIGNED;
                    end
                    else if (cur_phase == PH_LEAD && status.is_plus)
                    begin
                        state_next = PH_SIGNED;
                    end
                    else if (status.cfg_bad)
                    begin
                        cmd.emit   = EM_EMPTY;
                        state_next = PH_IDLE;
                    end
                    else if (status.is_zero && status.cfg_auto_hex)
                    begin
                        cmd.base_sel  = BS_ZERO;
                        cmd.acc_clear = 1'b1;
                        cmd.seen_set  = 1'b1;
                        state_next    = PH_ZERO;
                    end
                    else if (!status.first_ok)
                    begin
                        cmd.emit   = EM_EMPTY;
                        state_next = PH_IDLE;
                    end
                    else
                    begin
                        cmd.base_sel  = BS_FIRST;
                        cmd.acc_clear = 1'b1;
                        cmd.take      = 1'b1;
                        state_next    = PH_DIGITS;
                    end
                end
                PH_ZERO:
                begin
                    if (status.is_x)
                    begin
                        cmd.base_sel = BS_HEX;
                        cmd.mark     = 1'b1;
                        state_next   = PH_AFTER_X;
                    end
                    else if (status.digit_ok)
                    begin
                        cmd.take   = 1'b1;
                        state_next = PH_DIGITS;
                    end
                    else
                    begin
                        cmd.emit   = EM_VALUE;
                        state_next = PH_IDLE;
                    end
                end
                PH_AFTER_X:
                begin
                    if (status.hex_digit)
                    begin
                        cmd.acc_clear = 1'b1;
                        cmd.take      = 1'b1;
                        state_next    = PH_DIGITS;
                    end
                    else
                    begin
                        cmd.emit   = EM_PREFIX;
                        state_next = PH_IDLE;
                    end
                end
                PH_DIGITS:
                begin
                    if (status.digit_ok)
                    begin
                        cmd.take   = 1'b1;
                        state_next = PH_DIGITS;
                    end
                    else
                    begin
                        cmd.emit   = EM_VALUE;
                        state_next = PH_IDLE;
                    end
                end
                default:
                begin
                    state_next = PH_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_emit_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit != EM_NONE) |-> accept)
        else $error("result produced without an accepted beat");

    a_idle_ignores: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == PH_IDLE && !string_start) |-> !cmd.step)
        else $error("parser acted on a beat while idle");

    a_emit_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit != EM_NONE) |=> (state_reg == PH_IDLE))
        else $error("parser did not return to idle after a result");
`endif

endmodule

// File: hw/rtl/tup_dp.sv
module tup_dp
    import tup_pkg::*;
#(
    parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF,
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [BASE_WIDTH-1:0]   number_base,
    input  logic [CHAR_WIDTH-1:0]   char_code,
    input  cmd_t                    cmd,
    input  logic                    out_stall,
    output status_t                 status,
    output logic                    out_valid,
    output logic [VALUE_WIDTH-1:0]  parsed_value,
    output logic [OFFSET_WIDTH-1:0] end_offset,
    output logic                    overflowed,
    output logic                    digits_seen
);

    localparam int PROD_WIDTH = VALUE_WIDTH + BASE_WIDTH + 1;

    logic [BASE_WIDTH-1:0]   cfg_base_reg;
    logic [BASE_WIDTH-1:0]   base_reg;
    logic [BASE_WIDTH-1:0]   base_next;
    logic [VALUE_WIDTH-1:0]  acc_reg;
    logic [VALUE_WIDTH-1:0]  acc_next;
    logic [OFFSET_WIDTH-1:0] pos_reg;
    logic [OFFSET_WIDTH-1:0] pos_next;
    logic [OFFSET_WIDTH-1:0] mark_reg;
    logic                    neg_reg;
    logic                    neg_next;
    digit_status_t           dstat_reg;
    digit_status_t           dstat_next;

    logic                    out_valid_reg;
    logic [VALUE_WIDTH-1:0]  value_reg;
    logic [OFFSET_WIDTH-1:0] offset_reg;
    logic                    ovf_reg;
    logic                    seen_reg;

    logic [DIGIT_WIDTH-1:0]  digit;
    logic                    digit_valid;
    logic [BASE_WIDTH-1:0]   first_base;
    logic [VALUE_WIDTH-1:0]  acc_src;
    digit_status_t           dstat_src;
    logic [PROD_WIDTH-1:0]   prod;
    logic [VALUE_WIDTH-1:0]  final_value;

    always_comb
    begin
        digit       = '0;
        digit_valid = 1'b0;
        if (char_code >= CH_ZERO && char_code <= CH_NINE)
        begin
            digit       = DIGIT_WIDTH'(char_code - CH_ZERO);
            digit_valid = 1'b1;
        end
        else if (char_code >= CH_UPPER_A && char_code <= CH_UPPER_Z)
        begin
            digit       = DIGIT_WIDTH'(char_code - CH_UPPER_OFS);
            digit_valid = 1'b1;
        end
        else if (char_code >= CH_LOWER_A && char_code <= CH_LOWER_Z)
        begin
            digit       = DIGIT_WIDTH'(char_code - CH_LOWER_OFS);
            digit_valid = 1'b1;
        end
    end

    assign first_base = (cfg_base_reg == BASE_AUTO) ? BASE_DEC : cfg_base_reg;

    always_comb
    begin
        status.is_space     = (char_code == CH_SPACE) ||
                              (char_code >= CH_TAB && char_code <= CH_CR);
        status.is_minus     = (char_code == CH_MINUS);
        status.is_plus      = (char_code == CH_PLUS);
        status.is_zero      = (char_code == CH_ZERO);
        status.is_x         = (char_code == CH_LOWER_X) || (char_code == CH_UPPER_X);
        status.hex_digit    = digit_valid && (digit < BASE_HEX);
        status.cfg_bad      = (cfg_base_reg == BASE_UNIT) || (cfg_base_reg > BASE_MAX);
        status.cfg_auto_hex = (cfg_base_reg == BASE_AUTO) || (cfg_base_reg == BASE_HEX);
        status.first_ok     = digit_valid && (digit < first_base);
        status.digit_ok     = digit_valid && (digit < base_reg);
    end

    assign acc_src   = (cmd.restart || cmd.acc_clear) ? '0 : acc_reg;
    assign dstat_src = cmd.restart ? DS_NONE : dstat_reg;
    assign prod      = PROD_WIDTH'(acc_src) * PROD_WIDTH'(base_next) + PROD_WIDTH'(digit);

    always_comb
    begin
        unique case (cmd.base_sel)
            BS_FIRST: base_next = first_base;
            BS_ZERO:  base_next = (cfg_base_reg == BASE_AUTO) ? BASE_OCT : BASE_HEX;
            BS_HEX:   base_next = BASE_HEX;
            default:  base_next = cmd.restart ? '0 : base_reg;
        endcase
    end

    always_comb
    begin
        acc_next   = acc_src;
        dstat_next = dstat_src;
        if (cmd.seen_set)
        begin
            dstat_next = DS_SEEN;
        end
        if (cmd.take && dstat_src != DS_OVF)
        begin
            if (|prod[PROD_WIDTH-1:VALUE_WIDTH])
            begin
                dstat_next = DS_OVF;
            end
            else
            begin
                acc_next   = prod[VALUE_WIDTH-1:0];
                dstat_next = DS_SEEN;
            end
        end
        neg_next = cmd.set_neg || (!cmd.restart && neg_reg);
        if (cmd.restart)
        begin
            pos_next = '0;
        end
        else if (pos_reg != '1)
        begin
            pos_next = pos_reg + 1'b1;
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    always_comb
    begin
        if (dstat_reg == DS_OVF)
        begin
            final_value = '1;
        end
        else if (neg_reg)
        begin
            final_value = '0 - acc_reg;
        end
        else
        begin
            final_value = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_base_reg  <= BASE_AUTO;
            base_reg      <= '0;
            pos_reg       <= '0;
            neg_reg       <= 1'b0;
            dstat_reg     <= DS_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                cfg_base_reg <= number_base;
            end
            if (cmd.step)
            begin
                base_reg  <= base_next;
                pos_reg   <= pos_next;
                neg_reg   <= neg_next;
                dstat_reg <= dstat_next;
            end
            if (cmd.emit != EM_NONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.mark)
        begin
            mark_reg <= pos_next;
        end
        case (cmd.emit)
            EM_EMPTY:
            begin
                value_reg  <= '0;
                offset_reg <= '0;
                ovf_reg    <= 1'b0;
                seen_reg   <= 1'b0;
            end
            EM_VALUE:
            begin
                value_reg  <= final_value;
                offset_reg <= pos_next;
                ovf_reg    <= (dstat_reg == DS_OVF);
                seen_reg   <= 1'b1;
            end
            EM_PREFIX:
            begin
                value_reg  <= '0;
                offset_reg <= mark_reg;
                ovf_reg    <= 1'b0;
                seen_reg   <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign parsed_value = value_reg;
    assign end_offset   = offset_reg;
    assign overflowed   = ovf_reg;
    assign digits_seen  = seen_reg;

`ifndef ASSERT_OFF
    a_ovf_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ovf_reg) |-> (&value_reg))
        else $error("overflow result is not saturated");

    a_empty_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !seen_reg) |-> (value_reg == '0 && offset_reg == '0 && !ovf_reg))
        else $error("result without digits carries nonzero fields");

    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (dstat_reg == DS_OVF && !(cmd.step && cmd.restart)) |=> (dstat_reg == DS_OVF))
        else $error("overflow status cleared inside a string");
`endif

endmodule

// File: hw/rtl/text_to_unsigned64_parser.sv
// Streaming text-to-unsigned converter with strtoull semantics. Each input beat carries one
// character; a beat with string_start high begins a new string at index 0. Leading whitespace
// and one sign are skipped, a 0x or 0X prefix is taken in base 0 or 16, and base 0 picks
// octal or decimal from a leading zero. The first character that is not a digit of the active
// base produces one result beat; later characters are dropped until the next start, and a
// string cut off by a new start gives no result. Each character passes through the single
// multiply-add and overflow check of the accumulator, and a beat can be accepted in every
// cycle while the output register is free or being emptied. The base register is written
// through the cfg port, which is always ready, and must only change while no string is open.
module text_to_unsigned64_parser
    import tup_pkg::*;
#(
    parameter int VALUE_WIDTH  = VALUE_WIDTH_DEF,
    parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [BASE_WIDTH-1:0]   number_base,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [CHAR_WIDTH-1:0]   char_code,
    input  logic                    string_start,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [VALUE_WIDTH-1:0]  parsed_value,
    output logic [OFFSET_WIDTH-1:0] end_offset,
    output logic                    overflowed,
    output logic                    digits_seen
);

    cmd_t    cmd;
    status_t status;
    logic    accept;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid && out_stall;
    assign accept    = in_valid && !in_stall;

    tup_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .string_start (string_start),
        .status       (status),
        .cmd          (cmd)
    );

    tup_dp #(
        .VALUE_WIDTH  (VALUE_WIDTH),
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_valid && cfg_ready),
        .number_base  (number_base),
        .char_code    (char_code),
        .cmd          (cmd),
        .out_stall    (out_stall),
        .status       (status),
        .out_valid    (out_valid),
        .parsed_value (parsed_value),
        .end_offset   (end_offset),
        .overflowed   (overflowed),
        .digits_seen  (digits_seen)
    );

endmodule

// File: verif/tb_text_to_unsigned64_parser.sv
`timescale 1ns / 100ps

module tb_text_to_unsigned64_parser;
    import tup_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_BEATS = 50;
    localparam logic [CHAR_WIDTH-1:0] CH_NUL = 8'h00;
    localparam logic [63:0] ALL_ONES = {64{1'b1}};

    typedef struct packed {
        logic [CHAR_WIDTH-1:0] code;
        logic                  first;
    } char_beat_t;

    typedef struct packed {
        logic [63:0] value;
        logic [15:0] offset;
        logic        ovf;
        logic        seen;
    } parse_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [BASE_WIDTH-1:0]   number_base = BASE_AUTO;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [CHAR_WIDTH-1:0]   char_code = CH_NUL;
    logic                    string_start = 1'b0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [63:0]             parsed_value;
    logic [15:0]             end_offset;
    logic                    overflowed;
    logic                    digits_seen;

    phase_t                  scan_phase = PH_IDLE;
    digit_status_t           dstat = DS_NONE;
    logic [63:0]             acc = '0;
    logic                    minus = 1'b0;
    logic [BASE_WIDTH-1:0]   radix = '0;
    logic [15:0]             char_pos = '0;
    logic [63:0]             cutoff = '0;
    logic [BASE_WIDTH-1:0]   cut_digit = '0;
    logic [BASE_WIDTH-1:0]   radix_setting = BASE_AUTO;

    char_beat_t              pending_q[$];
    parse_result_t           expected_q[$];
    parse_result_t           want;
    int                      queued_beats = 0;
    int                      error_count = 0;
    int                      gap_left = 0;
    int                      stall_left = 0;
    int                      idle_cycles = 0;
    bit                      send_quiet = 1'b0;
    bit                      recv_quiet = 1'b0;
    bit                      fresh = 1'b1;

    text_to_unsigned64_parser DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .number_base  (number_base),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_code    (char_code),
        .string_start (string_start),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .parsed_value (parsed_value),
        .end_offset   (end_offset),
        .overflowed   (overflowed),
        .digits_seen  (digits_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int digit_val(input logic [CHAR_WIDTH-1:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return int'(c - CH_ZERO);
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
            return int'(c - CH_UPPER_OFS);
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
            return int'(c - CH_LOWER_OFS);
        return 99;
    endfunction

    function void post_result(input logic [63:0] v, input logic [15:0] o,
                              input logic f, input logic s);
        expected_q.push_back('{value: v, offset: o, ovf: f, seen: s});
        scan_phase = PH_IDLE;
    endfunction

    function void load_radix(input logic [BASE_WIDTH-1:0] b);
        radix = b;
        cutoff = ALL_ONES / b;
        cut_digit = BASE_WIDTH'(ALL_ONES % b);
    endfunction

    function void add_digit(input int d);
        if (dstat == DS_OVF)
            return;
        if (acc > cutoff || (acc == cutoff && d > cut_digit))
            dstat = DS_OVF;
        else
        begin
            acc = acc * radix + 64'(d);
            dstat = DS_SEEN;
        end
    endfunction

    function void take_first(input logic [CHAR_WIDTH-1:0] c);
        int d;
        logic [BASE_WIDTH-1:0] b;
        d = digit_val(c);
        b = radix_setting;
        if (b == BASE_UNIT || b > BASE_MAX)
            post_result('0, '0, 1'b0, 1'b0);
        else if (c == CH_ZERO && (b == BASE_AUTO || b == BASE_HEX))
        begin
            load_radix(b == BASE_AUTO ? BASE_OCT : BASE_HEX);
            acc = '0;
            dstat = DS_SEEN;
            scan_phase = PH_ZERO;
        end
        else
        begin
            if (b == BASE_AUTO)
                b = BASE_DEC;
            if (d >= b)
                post_result('0, '0, 1'b0, 1'b0);
            else
            begin
                load_radix(b);
                acc = '0;
                add_digit(d);
                scan_phase = PH_DIGITS;
            end
        end
    endfunction

    function void take_digit(input logic [CHAR_WIDTH-1:0] c);
        int d;
        d = digit_val(c);
        if (d >= radix)
            post_result(dstat == DS_OVF ? ALL_ONES : (minus ? -acc : acc), char_pos,
                        dstat == DS_OVF, 1'b1);
        else
        begin
            add_digit(d);
            scan_phase = PH_DIGITS;
        end
    endfunction

    function void predict_beat(input logic [CHAR_WIDTH-1:0] c, input logic first);
        if (first)
        begin
            scan_phase = PH_LEAD;
            acc = '0;
            minus = 1'b0;
            dstat = DS_NONE;
            radix = '0;
            char_pos = '0;
            cutoff = '0;
            cut_digit = '0;
        end
        else if (scan_phase == PH_IDLE)
            return;
        else if (char_pos != 16'hFFFF)
            char_pos++;

        case (scan_phase)
            PH_LEAD:
                if (c == CH_MINUS)
                begin
                    minus = 1'b1;
                    scan_phase = PH_SIGNED;
                end
                else if (c == CH_PLUS)
                    scan_phase = PH_SIGNED;
                else if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)))
                    take_first(c);
            PH_SIGNED:
                take_first(c);
            PH_ZERO:
                if (c == CH_LOWER_X || c == CH_UPPER_X)
                begin
                    load_radix(BASE_HEX);
                    acc = 64'(char_pos);
                    scan_phase = PH_AFTER_X;
                end
                else
                    take_digit(c);
            PH_AFTER_X:
                if (digit_val(c) < 16)
                begin
                    acc = '0;
                    take_digit(c);
                end
                else
                    post_result('0, acc[15:0], 1'b0, 1'b1);
            PH_DIGITS:
                take_digit(c);
            default:
                scan_phase = PH_IDLE;
        endcase
    endfunction

    function void queue_beat(input logic [CHAR_WIDTH-1:0] c, input logic first);
        pending_q.push_back('{code: c, first: first});
        queued_beats++;
    endfunction

    function void queue_text(input logic [CHAR_WIDTH-1:0] c);
        queue_beat(c, fresh);
        fresh = 1'b0;
    endfunction

    function void queue_literal(input string s);
        fresh = 1'b1;
        for (int i = 0; i < s.len(); i++)
            queue_text(s[i]);
    endfunction

    function automatic logic [CHAR_WIDTH-1:0] digit_glyph(input int d);
        if (d < 10)
            return CH_ZERO + CHAR_WIDTH'(d);
        return ($urandom_range(0, 1) ? CH_UPPER_OFS : CH_LOWER_OFS) + CHAR_WIDTH'(d);
    endfunction

    // Mostly well-formed numbers in the radix that the setting implies, with random
    // whitespace, sign, prefix, value shape and terminator.
    function automatic void queue_number(input logic [BASE_WIDTH-1:0] setting);
        int eff;
        int shape;
        logic [63:0] v;
        logic [CHAR_WIDTH-1:0] c;
        int digs[$];
        fresh = 1'b1;
        repeat ($urandom_range(0, 2))
            queue_text($urandom_range(0, 1) ? CH_SPACE
                                            : CHAR_WIDTH'($urandom_range(CH_TAB, CH_CR)));
        case ($urandom_range(0, 3))
            0: queue_text(CH_MINUS);
            1: queue_text(CH_PLUS);
            default: ;
        endcase
        if (setting == BASE_AUTO)
        begin
            case ($urandom_range(0, 2))
                0: eff = BASE_OCT;
                1: eff = BASE_DEC;
                default: eff = BASE_HEX;
            endcase
        end
        else if (setting >= 2 && setting <= BASE_MAX)
            eff = setting;
        else
            eff = BASE_DEC;
        if (eff == BASE_HEX && (setting == BASE_AUTO || $urandom_range(0, 1)))
        begin
            queue_text(CH_ZERO);
            queue_text($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
        end
        else if (setting == BASE_AUTO && eff == BASE_OCT)
            queue_text(CH_ZERO);
        shape = $urandom_range(0, 6);
        case (shape)
            1: v = 64'($urandom_range(0, 999));
            2: v = {$urandom, $urandom};
            5: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            default: v = ALL_ONES;
        endcase
        if (shape != 0)
        begin
            do
            begin
                digs.push_front(int'(v % eff));
                v = v / eff;
            end
            while (v != 0);
            if (shape == 4)
                repeat ($urandom_range(1, 2))
                    digs.push_back($urandom_range(0, eff - 1));
            if (shape == 6 && digs[$] < eff - 1)
                digs[$] = digs[$] + 1;
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 3))
                    digs.push_front(0);
            foreach (digs[i])
                queue_text(digit_glyph(digs[i]));
        end
        if ($urandom_range(0, 9) != 0)
        begin
            do
                c = CHAR_WIDTH'($urandom_range(0, 255));
            while (digit_val(c) < eff);
            queue_text(c);
            repeat ($urandom_range(0, 2))
                queue_beat(CHAR_WIDTH'($urandom_range(0, 255)), 1'b0);
        end
    endfunction

    task write_radix(input logic [BASE_WIDTH-1:0] b);
        @(posedge clk);
        cfg_valid <= 1'b1;
        number_base <= b;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        radix_setting = b;
    endtask

    task wait_idle();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || in_valid || expected_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_beat(char_code, string_start);
                void'(pending_q.pop_front());
                if ($urandom_range(0, 31) == 0)
                    send_quiet = !send_quiet;
                gap_left = send_quiet ? 0 : $urandom_range(0, 4);
            end
            if (!(in_valid && in_stall))
            begin
                if (gap_left > 0 || pending_q.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
                else
                begin
                    in_valid <= 1'b1;
                    char_code <= pending_q[0].code;
                    string_start <= pending_q[0].first;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result beat with nothing pending: parsed_value %h", parsed_value);
                    error_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (parsed_value !== want.value)
                    begin
                        $error("parsed_value: expected %h, actual %h", want.value, parsed_value);
                        error_count++;
                    end
                    if (end_offset !== want.offset)
                    begin
                        $error("end_offset: expected %0d, actual %0d", want.offset, end_offset);
                        error_count++;
                    end
                    if (overflowed !== want.ovf)
                    begin
                        $error("overflowed: expected %b, actual %b", want.ovf, overflowed);
                        error_count++;
                    end
                    if (digits_seen !== want.seen)
                    begin
                        $error("digits_seen: expected %b, actual %b", want.seen, digits_seen);
                        error_count++;
                    end
                end
                if ($urandom_range(0, 31) == 0)
                    recv_quiet = !recv_quiet;
                stall_left = recv_quiet ? 0 : $urandom_range(0, 4);
            end
            out_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("text_to_unsigned64_parser verification failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        logic [BASE_WIDTH-1:0] plan [10];
        int phase_mark;
        plan = '{BASE_HEX, BASE_MAX, 6'd2, BASE_UNIT, BASE_OCT, 6'd63, BASE_DEC, 6'd37,
                 BASE_AUTO, BASE_AUTO};
        plan[8] = BASE_WIDTH'($urandom_range(2, 36));

        // A beat before any start must be dropped.
        queue_beat("5", 1'b0);
        queue_beat(CH_NUL, 1'b1);
        queue_literal(" -12!");
        queue_literal("0Xg");
        queue_literal("017");
        queue_beat(8'hFF, 1'b0);
        queue_literal("\t+0x1f.");
        queue_beat("5", 1'b0);
        queue_literal("9");
        queue_beat(CH_NUL, 1'b1);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        wait_idle();

        foreach (plan[i])
        begin
            write_radix(plan[i]);
            phase_mark = queued_beats;
            while (queued_beats - phase_mark < PHASE_BEATS)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    queue_beat(CHAR_WIDTH'($urandom_range(0, 255)), 1'b1);
                    repeat ($urandom_range(0, 5))
                        queue_beat(CHAR_WIDTH'($urandom_range(0, 255)),
                                   $urandom_range(0, 5) == 0);
                end
                else
                    queue_number(plan[i]);
            end
            queue_beat(CH_NUL, 1'b1);
            wait_idle();
        end

        repeat (5) @(negedge clk);
        if (error_count == 0)
            $display("text_to_unsigned64_parser verification clean");
        else
            $display("text_to_unsigned64_parser verification failed");
        $finish;
    end

endmodule
